// File: src/akf_pkg.sv
package akf_pkg;

    localparam int unsigned WORD_W = 32;
    localparam int unsigned REG_W  = 31;
    localparam int unsigned IDX_W  = 2;

    // configuration register indexes
    localparam logic [IDX_W-1:0] REG_QA = 2'd0;
    localparam logic [IDX_W-1:0] REG_QB = 2'd1;
    localparam logic [IDX_W-1:0] REG_R  = 2'd2;

    localparam logic signed [WORD_W-1:0] SAT_MAX = 32'sh7FFF_FFFF;
    localparam logic signed [WORD_W-1:0] SAT_MIN = 32'sh8000_0000;

    // operations of the shared arithmetic unit
    typedef enum logic [1:0] {
        OP_MUL,
        OP_ADD,
        OP_SUB,
        OP_DIV
    } t_op;

    // unit request
    typedef struct packed {
        logic                     start;
        t_op                      op;
        logic signed [WORD_W-1:0] a;
        logic signed [WORD_W-1:0] b;
    } t_alu_req;

    // unit response
    typedef struct packed {
        logic                     done;
        logic signed [WORD_W-1:0] y;
    } t_alu_rsp;

    // sequencer states
    typedef enum logic [1:0] {
        ST_IDLE,
        ST_ISSUE,
        ST_WAIT,
        ST_OUT
    } t_state;

    // saturate a 66-bit signed value to 32 bits
    function automatic logic signed [WORD_W-1:0] sat66(input logic signed [65:0] v);
        logic signed [65:0] hi;
        logic signed [65:0] lo;
        hi = 66'(SAT_MAX);
        lo = 66'(SAT_MIN);
        if (v > hi) begin
            return SAT_MAX;
        end else if (v < lo) begin
            return SAT_MIN;
        end
        return v[WORD_W-1:0];
    endfunction

endpackage

// File: src/akf_alu.sv
module akf_alu #(
    parameter int FRAC_BITS = 20
) (
    input  logic              i_clk,
    input  logic              i_rst_n,
    input  akf_pkg::t_alu_req i_req,
    output akf_pkg::t_alu_rsp o_rsp
);
    import akf_pkg::*;

    localparam int QW  = WORD_W + FRAC_BITS;   // quotient width before saturation
    localparam int CW  = $clog2(QW + 1);

    // multiply / add path, one register stage before shift
    logic              r_busy, n_busy;
    logic              r_mul_pend, n_mul_pend;
    logic signed [63:0] r_prod;
    t_op               r_op;
    logic signed [WORD_W-1:0] r_y, n_y;
    logic              r_done, n_done;

    // restoring divider
    logic [CW-1:0]     r_cnt, n_cnt;
    logic [QW-1:0]     r_num, n_num;
    logic [QW-1:0]     r_quo, n_quo;
    logic [WORD_W:0]   r_rem, n_rem;
    logic [WORD_W-1:0] r_den;
    logic              r_neg, n_neg;

    logic signed [65:0] sum;
    logic signed [63:0] shf;
    logic [WORD_W+1:0]  trial;
    logic [WORD_W:0]    rem_sh;
    logic [65:0]        qext;

    always_comb begin
        n_busy     = r_busy;
        n_mul_pend = 1'b0;
        n_y        = r_y;
        n_done     = 1'b0;
        n_cnt      = r_cnt;
        n_num      = r_num;
        n_quo      = r_quo;
        n_rem      = r_rem;
        n_neg      = r_neg;
        sum        = 66'(i_req.a) + 66'(i_req.b);
        shf        = r_prod >>> FRAC_BITS;
        rem_sh     = {r_rem[WORD_W-1:0], r_num[QW-1]};
        trial      = {1'b0, rem_sh} - {2'b0, r_den};
        qext       = 66'(r_quo);
        if (i_req.start) begin
            unique case (i_req.op)
                OP_MUL: begin
                    n_busy     = 1'b1;
                    n_mul_pend = 1'b1;
                end
                OP_ADD: begin
                    n_y    = sat66(sum);
                    n_done = 1'b1;
                end
                OP_SUB: begin
                    sum    = 66'(i_req.a) - 66'(i_req.b);
                    n_y    = sat66(sum);
                    n_done = 1'b1;
                end
                OP_DIV: begin
                    n_busy = 1'b1;
                    n_neg  = i_req.a[WORD_W-1];
                    n_num  = QW'(i_req.a[WORD_W-1] ? -66'(i_req.a) : 66'(i_req.a))
                             << FRAC_BITS;
                    n_quo  = '0;
                    n_rem  = '0;
                    n_cnt  = CW'(QW);
                end
                default: ;
            endcase
        end else if (r_mul_pend) begin
            n_y    = sat66(66'(shf));
            n_done = 1'b1;
            n_busy = 1'b0;
        end else if (r_busy && r_op == OP_DIV) begin
            // one quotient bit a cycle
            if (!trial[WORD_W+1]) begin
                n_rem = trial[WORD_W:0];
                n_quo = {r_quo[QW-2:0], 1'b1};
            end else begin
                n_rem = rem_sh;
                n_quo = {r_quo[QW-2:0], 1'b0};
            end
            n_num = r_num << 1;
            n_cnt = r_cnt - 1'b1;
            if (r_cnt == CW'(1)) begin
                qext   = 66'(n_quo);
                n_y    = sat66(r_neg ? -qext : qext);
                n_done = 1'b1;
                n_busy = 1'b0;
            end
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_busy     <= 1'b0;
            r_mul_pend <= 1'b0;
            r_done     <= 1'b0;
            r_cnt      <= '0;
        end else begin
            r_busy     <= n_busy;
            r_mul_pend <= n_mul_pend;
            r_done     <= n_done;
            r_cnt      <= n_cnt;
        end
        r_y   <= n_y;
        r_num <= n_num;
        r_quo <= n_quo;
        r_rem <= n_rem;
        r_neg <= n_neg;
        if (i_req.start) begin
            r_op   <= i_req.op;
            r_den  <= i_req.b;
            r_prod <= 64'(i_req.a) * 64'(i_req.b);
        end
    end

    assign o_rsp.done = r_done;
    assign o_rsp.y    = r_y;

`ifndef ASSERT_OFF
    a_no_start_busy: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        r_busy |-> !i_req.start) else $error("start while unit busy");
    a_done_pulse: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        r_done |=> !r_done || $past(i_req.start)) else $error("done held");
    a_mul_one: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        r_mul_pend |=> r_done) else $error("multiply late");
`endif

endmodule

// File: src/akf_seq.sv
module akf_seq (
    input  logic                              i_clk,
    input  logic                              i_rst_n,
    input  logic                              i_in_valid,
    output logic                              o_in_stall,
    input  logic signed [akf_pkg::WORD_W-1:0] i_meas,
    input  logic signed [akf_pkg::WORD_W-1:0] i_rate,
    input  logic        [akf_pkg::REG_W-1:0]  i_dt,
    input  logic        [akf_pkg::REG_W-1:0]  i_qa,
    input  logic        [akf_pkg::REG_W-1:0]  i_qb,
    input  logic        [akf_pkg::REG_W-1:0]  i_r,
    output logic                              o_out_valid,
    input  logic                              i_out_stall,
    output logic signed [akf_pkg::WORD_W-1:0] o_angle,
    output logic                              o_degen,
    output akf_pkg::t_alu_req                 o_req,
    input  akf_pkg::t_alu_rsp                 i_rsp
);
    import akf_pkg::*;

    localparam int NSTEP = 29;
    localparam int SW    = $clog2(NSTEP);

    // operand / destination register file indexes
    typedef enum logic [3:0] {
        V_ANG, V_BIAS, V_P00, V_P01, V_P10, V_P11,
        V_MEAS, V_RATE, V_DT, V_QA, V_QB, V_R,
        V_T, V_M, V_K0, V_K1
    } t_var;

    typedef enum logic [3:0] {
        X_Y, X_S, X_S00, X_S01, X_NONE
    } t_xtra;

    typedef struct packed {
        t_op   op;
        logic  ax; logic [3:0] a;
        logic  bx; logic [3:0] b;
        logic  dx; logic [3:0] d;
    } t_step;

    logic signed [WORD_W-1:0] r_v [16];
    logic signed [WORD_W-1:0] r_x [4];
    t_state      r_state, n_state;
    logic [SW-1:0] r_step, n_step;
    logic        r_ov, n_ov;

    function automatic t_step st(input t_op op, input logic ax, input logic [3:0] a,
                                 input logic bx, input logic [3:0] b,
                                 input logic dx, input logic [3:0] d);
        t_step s;
        s = '{op: op, ax: ax, a: a, bx: bx, b: b, dx: dx, d: d};
        return s;
    endfunction

    // microprogram; scratch: X_Y rate/y, X_S s
    function automatic t_step prog(input logic [SW-1:0] i);
        t_step s;
        s = st(OP_ADD, 0, V_T, 0, V_T, 0, V_T);
        unique case (i)
            5'd0:  s = st(OP_SUB, 0, V_RATE, 0, V_BIAS, 1, X_Y);
            5'd1:  s = st(OP_MUL, 0, V_DT, 1, X_Y, 1, X_Y);
            5'd2:  s = st(OP_ADD, 0, V_ANG, 1, X_Y, 0, V_ANG);
            5'd3:  s = st(OP_MUL, 0, V_DT, 0, V_P11, 0, V_M);
            5'd4:  s = st(OP_SUB, 0, V_M, 0, V_P01, 0, V_T);
            5'd5:  s = st(OP_SUB, 0, V_T, 0, V_P10, 0, V_T);
            5'd6:  s = st(OP_ADD, 0, V_T, 0, V_QA, 0, V_T);
            5'd7:  s = st(OP_MUL, 0, V_DT, 0, V_T, 0, V_T);
            5'd8:  s = st(OP_ADD, 0, V_P00, 0, V_T, 0, V_P00);
            5'd9:  s = st(OP_SUB, 0, V_P01, 0, V_M, 0, V_P01);
            5'd10: s = st(OP_SUB, 0, V_P10, 0, V_M, 0, V_P10);
            5'd11: s = st(OP_MUL, 0, V_QB, 0, V_DT, 0, V_T);
            5'd12: s = st(OP_ADD, 0, V_P11, 0, V_T, 0, V_P11);
            5'd13: s = st(OP_ADD, 0, V_P00, 0, V_R, 1, X_S);
            5'd14: s = st(OP_DIV, 0, V_P00, 1, X_S, 0, V_K0);
            5'd15: s = st(OP_DIV, 0, V_P10, 1, X_S, 0, V_K1);
            5'd16: s = st(OP_SUB, 0, V_MEAS, 0, V_ANG, 1, X_Y);
            5'd17: s = st(OP_MUL, 0, V_K0, 1, X_Y, 0, V_T);
            5'd18: s = st(OP_ADD, 0, V_ANG, 0, V_T, 0, V_ANG);
            5'd19: s = st(OP_MUL, 0, V_K1, 1, X_Y, 0, V_T);
            5'd20: s = st(OP_ADD, 0, V_BIAS, 0, V_T, 0, V_BIAS);
            5'd21: s = st(OP_ADD, 0, V_P00, 1, X_NONE, 1, X_S00);
            5'd22: s = st(OP_ADD, 0, V_P01, 1, X_NONE, 1, X_S01);
            5'd23: s = st(OP_MUL, 0, V_K0, 1, X_S00, 0, V_T);
            5'd24: s = st(OP_SUB, 0, V_P00, 0, V_T, 0, V_P00);
            5'd25: s = st(OP_MUL, 0, V_K0, 1, X_S01, 0, V_T);
            5'd26: s = st(OP_SUB, 0, V_P01, 0, V_T, 0, V_P01);
            5'd27: s = st(OP_MUL, 0, V_K1, 1, X_S00, 0, V_M);
            5'd28: s = st(OP_SUB, 0, V_P10, 0, V_M, 0, V_P10);
            default: ;
        endcase
        return s;
    endfunction

    t_step cur;
    logic  last, s_bad;
    logic signed [WORD_W-1:0] opa, opb;

    // k1*p01 for P11 reuses step 27/28 pattern: extra two steps appended below
    logic        r_tail, n_tail;

    always_comb begin
        cur = prog(r_step);
        if (r_tail) begin
            cur = r_step[0] ? st(OP_SUB, 0, V_P11, 0, V_M, 0, V_P11)
                            : st(OP_MUL, 0, V_K1, 1, X_S01, 0, V_M);
        end
        opa = cur.ax ? (cur.a[2] ? '0 : r_x[cur.a[1:0]]) : r_v[cur.a];
        opb = cur.bx ? (cur.b[2] ? '0 : r_x[cur.b[1:0]]) : r_v[cur.b];
        o_req.start = (r_state == ST_ISSUE);
        o_req.op    = cur.op;
        o_req.a     = opa;
        o_req.b     = opb;
    end

    assign s_bad = (i_rsp.y[WORD_W-1] || i_rsp.y == '0);
    assign last  = r_tail && r_step[0];

    // sequencer
    always_comb begin
        n_state = r_state;
        n_step  = r_step;
        n_tail  = r_tail;
        n_ov    = r_ov;
        unique case (r_state)
            ST_IDLE: begin
                if (i_in_valid) begin
                    n_state = ST_ISSUE;
                    n_step  = '0;
                    n_tail  = 1'b0;
                end
            end
            ST_ISSUE: n_state = ST_WAIT;
            ST_WAIT: begin
                if (i_rsp.done) begin
                    if (!r_tail && r_step == SW'(13) && s_bad) begin
                        n_state = ST_OUT;
                        n_ov    = 1'b1;
                    end else if (last) begin
                        n_state = ST_OUT;
                        n_ov    = 1'b0;
                    end else if (!r_tail && r_step == SW'(NSTEP-1)) begin
                        n_tail  = 1'b1;
                        n_step  = '0;
                        n_state = ST_ISSUE;
                    end else begin
                        n_step  = r_step + 1'b1;
                        n_state = ST_ISSUE;
                    end
                end
            end
            ST_OUT: if (!i_out_stall) n_state = ST_IDLE;
            default: n_state = ST_IDLE;
        endcase
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state <= ST_IDLE;
            r_step  <= '0;
            r_tail  <= 1'b0;
            r_ov    <= 1'b0;
            for (int k = 0; k < 6; k++) r_v[k] <= '0;
        end else begin
            r_state <= n_state;
            r_step  <= n_step;
            r_tail  <= n_tail;
            r_ov    <= n_ov;
            if (r_state == ST_IDLE && i_in_valid) begin
                r_v[V_MEAS] <= i_meas;
                r_v[V_RATE] <= i_rate;
                r_v[V_DT]   <= WORD_W'(i_dt);
                r_v[V_QA]   <= WORD_W'(i_qa);
                r_v[V_QB]   <= WORD_W'(i_qb);
                r_v[V_R]    <= WORD_W'(i_r);
            end
            if (r_state == ST_WAIT && i_rsp.done) begin
                if (cur.dx) r_x[cur.d[1:0]] <= i_rsp.y;
                else        r_v[cur.d]      <= i_rsp.y;
            end
        end
    end

    assign o_in_stall  = (r_state != ST_IDLE);
    assign o_out_valid = (r_state == ST_OUT);
    assign o_angle     = r_v[V_ANG];
    assign o_degen     = r_ov;

`ifndef ASSERT_OFF
    a_issue_wait: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        r_state == ST_ISSUE |=> r_state == ST_WAIT) else $error("issue not followed by wait");
    a_out_hold: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (o_out_valid && i_out_stall) |=> o_out_valid && $stable(o_angle))
        else $error("result changed under stall");
    a_done_wait: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        i_rsp.done |-> r_state == ST_WAIT) else $error("response outside wait");
`endif

endmodule

// File: src/angle_kalman_filter_two_state.sv
// channel | valid       | stall       | word
// in      | i_in_valid  | o_in_stall  | measured_angle, gyro_rate, time_step
// out     | o_out_valid | i_out_stall | filtered_angle, degenerate_gain
// cfg     | i_cfg_valid | o_cfg_ready | i_cfg_index, i_cfg_data
// A full update runs 31 steps from acceptance to the offered result; each step
// issues one operation to the shared unit and waits for its response: add/sub,
// multiply, or the 52-bit divider (run twice).
// A skipped update ends after 14 steps.
// Reset is synchronous, active low, loads the noise registers with their
// defaults and clears the state. The input stalls until the result is taken.
module angle_kalman_filter_two_state #(
    parameter int FRAC_BITS = 20
) (
    input  logic                              i_clk,
    input  logic                              i_rst_n,
    input  logic                              i_in_valid,
    output logic                              o_in_stall,
    input  logic signed [akf_pkg::WORD_W-1:0] i_measured_angle,
    input  logic signed [akf_pkg::WORD_W-1:0] i_gyro_rate,
    input  logic        [akf_pkg::REG_W-1:0]  i_time_step,
    output logic                              o_out_valid,
    input  logic                              i_out_stall,
    output logic signed [akf_pkg::WORD_W-1:0] o_filtered_angle,
    output logic                              o_degenerate_gain,
    input  logic                              i_cfg_valid,
    output logic                              o_cfg_ready,
    input  logic        [akf_pkg::IDX_W-1:0]  i_cfg_index,
    input  logic        [akf_pkg::REG_W-1:0]  i_cfg_data
);
    import akf_pkg::*;

    localparam logic [REG_W-1:0] QA_RST = REG_W'(((64'd1 << FRAC_BITS) + 64'd500) / 64'd1000);
    localparam logic [REG_W-1:0] QB_RST = REG_W'(((64'd3 << FRAC_BITS) + 64'd500) / 64'd1000);
    localparam logic [REG_W-1:0] R_RST  = REG_W'(((64'd3 << FRAC_BITS) + 64'd50) / 64'd100);

    logic [REG_W-1:0] r_qa, r_qb, r_r;
    t_alu_req req;
    t_alu_rsp rsp;

    // configuration registers
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_qa <= QA_RST;
            r_qb <= QB_RST;
            r_r  <= R_RST;
        end else if (i_cfg_valid) begin
            if (i_cfg_index == REG_QA) r_qa <= i_cfg_data;
            if (i_cfg_index == REG_QB) r_qb <= i_cfg_data;
            if (i_cfg_index == REG_R)  r_r  <= i_cfg_data;
        end
    end
    assign o_cfg_ready = 1'b1;

    akf_seq u_seq (
        .i_clk       (i_clk),
        .i_rst_n     (i_rst_n),
        .i_in_valid  (i_in_valid),
        .o_in_stall  (o_in_stall),
        .i_meas      (i_measured_angle),
        .i_rate      (i_gyro_rate),
        .i_dt        (i_time_step),
        .i_qa        (r_qa),
        .i_qb        (r_qb),
        .i_r         (r_r),
        .o_out_valid (o_out_valid),
        .i_out_stall (i_out_stall),
        .o_angle     (o_filtered_angle),
        .o_degen     (o_degenerate_gain),
        .o_req       (req),
        .i_rsp       (rsp)
    );

    akf_alu #(.FRAC_BITS(FRAC_BITS)) u_alu (
        .i_clk   (i_clk),
        .i_rst_n (i_rst_n),
        .i_req   (req),
        .o_rsp   (rsp)
    );

`ifndef ASSERT_OFF
    a_in_out_excl: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        o_out_valid |-> o_in_stall) else $error("input open with result pending");
    a_out_after: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (o_out_valid && !i_out_stall) |=> !o_out_valid) else $error("result repeated");
    a_stall_after: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (i_in_valid && !o_in_stall) |=> o_in_stall) else $error("input not held off");
`endif

endmodule

// File: tb/testbench.sv
`timescale 1ns / 100ps

module testbench;
    import akf_pkg::*;

    localparam int FRAC     = 20;
    localparam int LIMIT    = 2_000_000;
    localparam int HOLD_LEN = 3000;
    localparam int N_RAND_PHASES = 8;
    localparam int WORDS_PER_PHASE = 250;

    // index past the last register; writes there must be dropped
    localparam logic [IDX_W-1:0] REG_NONE = 2'd3;

    localparam logic [REG_W-1:0] DEF_QA  = 31'd1049;
    localparam logic [REG_W-1:0] DEF_QB  = 31'd3146;
    localparam logic [REG_W-1:0] DEF_R   = 31'd31457;
    localparam logic [REG_W-1:0] REG_MAX = 31'h7FFF_FFFF;

    localparam logic signed [31:0] Q_ONE = 32'sh0010_0000;

    logic                     i_clk;
    logic                     i_rst_n;
    logic                     i_in_valid;
    logic                     o_in_stall;
    logic signed [WORD_W-1:0] i_measured_angle;
    logic signed [WORD_W-1:0] i_gyro_rate;
    logic        [REG_W-1:0]  i_time_step;
    logic                     o_out_valid;
    logic                     i_out_stall;
    logic signed [WORD_W-1:0] o_filtered_angle;
    logic                     o_degenerate_gain;
    logic                     i_cfg_valid;
    logic                     o_cfg_ready;
    logic        [IDX_W-1:0]  i_cfg_index;
    logic        [REG_W-1:0]  i_cfg_data;

    angle_kalman_filter_two_state #(.FRAC_BITS(FRAC)) DUT (.*);

    // expected output word
    typedef struct packed {
        logic signed [31:0] angle;
        logic               degen;
    } t_filter_out;

    // directed row: typed expectation only where has_exp is set
    typedef struct packed {
        logic signed [31:0] meas;
        logic signed [31:0] rate;
        logic [30:0]        dt;
        logic               has_exp;
        logic signed [31:0] exp_angle;
        logic               exp_degen;
    } t_row;

    localparam int N_DIR = 16;
    localparam t_row DIR_ROWS [N_DIR] = '{
        // defaults, fresh state: zero step, gain zero, angle stays at zero
        '{32'sh0050_0000, 32'sh0,          31'd0,          1'b1, 32'sh0, 1'b0},
        '{Q_ONE,          32'sh0008_0000,  31'd10486,      1'b0, 32'sh0, 1'b0},
        '{32'sh7FFF_FFFF, 32'sh7FFF_FFFF,  31'h7FFF_FFFF,  1'b0, 32'sh0, 1'b0},
        '{32'sh8000_0000, 32'sh8000_0000,  31'h7FFF_FFFF,  1'b0, 32'sh0, 1'b0},
        '{32'sh0,         32'sh8000_0000,  31'd1,          1'b0, 32'sh0, 1'b0},
        '{-Q_ONE,         32'sh0020_0000,  31'h4000_0000,  1'b0, 32'sh0, 1'b0},
        '{32'sh7FFF_FFFF, 32'sh0,          31'd0,          1'b0, 32'sh0, 1'b0},
        // zero noise: first zero step drives P00 to zero or below, second skips
        '{Q_ONE,          32'sh0,          31'd0,          1'b0, 32'sh0, 1'b0},
        '{32'sh0020_0000, 32'sh0,          31'd0,          1'b0, 32'sh0, 1'b0},
        '{32'sh8000_0000, 32'sh7FFF_FFFF,  31'd0,          1'b0, 32'sh0, 1'b0},
        // all noise registers at max
        '{Q_ONE,          -Q_ONE,          31'd10486,      1'b0, 32'sh0, 1'b0},
        '{32'sh7FFF_FFFF, 32'sh8000_0000,  31'h7FFF_FFFF,  1'b0, 32'sh0, 1'b0},
        '{32'sh8000_0000, 32'sh7FFF_FFFF,  31'd1,          1'b0, 32'sh0, 1'b0},
        '{32'sh0,         32'sh0,          31'h0000_0400,  1'b0, 32'sh0, 1'b0},
        // defaults again, after a write to an unused index
        '{32'sh0003_0000, 32'sh0001_0000,  31'd20972,      1'b0, 32'sh0, 1'b0},
        '{-32'sh0003_0000, 32'sh0,         31'd20972,      1'b0, 32'sh0, 1'b0}
    };

    // filter model state
    logic signed [31:0] cfg_qa, cfg_qb, cfg_r;
    logic signed [31:0] est_angle, est_bias;
    logic signed [31:0] p00, p01, p10, p11;

    t_filter_out expected_outputs[$];
    int          err_count;
    int          cycle_count;
    logic        quiet;
    logic        hold_req;
    logic        hold_done;
    int          hold_cnt;

    function automatic logic signed [31:0] sat32(input longint v);
        if (v > 64'sh7FFF_FFFF) return SAT_MAX;
        if (v < -64'sh8000_0000) return SAT_MIN;
        return v[31:0];
    endfunction

    // product, floored shift, saturate
    function automatic logic signed [31:0] fx_mul(input logic signed [31:0] a,
                                                 input logic signed [31:0] b);
        longint p;
        p = longint'(a) * longint'(b);
        return sat32(p >>> FRAC);
    endfunction

    function automatic logic signed [31:0] fx_add(input logic signed [31:0] a,
                                                 input logic signed [31:0] b);
        return sat32(longint'(a) + longint'(b));
    endfunction

    function automatic logic signed [31:0] fx_sub(input logic signed [31:0] a,
                                                 input logic signed [31:0] b);
        return sat32(longint'(a) - longint'(b));
    endfunction

    // quotient truncates toward zero
    function automatic logic signed [31:0] fx_div(input logic signed [31:0] n,
                                                 input logic signed [31:0] d);
        return sat32((longint'(n) * (64'sd1 <<< FRAC)) / longint'(d));
    endfunction

    task automatic filter_config(input logic [IDX_W-1:0] idx, input logic [REG_W-1:0] val);
        case (idx)
            REG_QA: cfg_qa = {1'b0, val};
            REG_QB: cfg_qb = {1'b0, val};
            REG_R:  cfg_r  = {1'b0, val};
            default: ;
        endcase
    endtask

    // one predict/update step of the two-state filter
    task automatic kf_predict_step(input logic signed [31:0] meas,
                                   input logic signed [31:0] rate_in,
                                   input logic [30:0] dt_in,
                                   output t_filter_out res);
        logic signed [31:0] dt, rate, t, m, s, k0, k1, y, old00, old01;
        dt   = {1'b0, dt_in};
        rate = fx_sub(rate_in, est_bias);
        est_angle = fx_add(est_angle, fx_mul(dt, rate));
        t = fx_sub(fx_mul(dt, p11), p01);
        t = fx_sub(t, p10);
        t = fx_add(t, cfg_qa);
        p00 = fx_add(p00, fx_mul(dt, t));
        m = fx_mul(dt, p11);
        p01 = fx_sub(p01, m);
        p10 = fx_sub(p10, m);
        p11 = fx_add(p11, fx_mul(cfg_qb, dt));
        s = fx_add(p00, cfg_r);
        if (s <= 0) begin
            res.angle = est_angle;
            res.degen = 1'b1;
            return;
        end
        k0 = fx_div(p00, s);
        k1 = fx_div(p10, s);
        y  = fx_sub(meas, est_angle);
        est_angle = fx_add(est_angle, fx_mul(k0, y));
        est_bias  = fx_add(est_bias, fx_mul(k1, y));
        old00 = p00;
        old01 = p01;
        p00 = fx_sub(p00, fx_mul(k0, old00));
        p01 = fx_sub(p01, fx_mul(k0, old01));
        p10 = fx_sub(p10, fx_mul(k1, old00));
        p11 = fx_sub(p11, fx_mul(k1, old01));
        res.angle = est_angle;
        res.degen = 1'b0;
    endtask

    task automatic report_mismatch(input string what, input longint got, input longint want);
        err_count++;
        if (err_count <= 50)
            $display("MISMATCH t=%0t %s: got %0d expected %0d", $time, what, got, want);
    endtask

    // clock and cycle limit
    initial i_clk = 1'b0;
    always #5 i_clk = ~i_clk;

    always @(posedge i_clk) begin
        cycle_count <= cycle_count + 1;
        if (cycle_count > LIMIT) begin
            $display("[FAIL] regression broken");
            $finish;
        end
    end

    // receiver: random stalls, one long hold-off on request
    always @(posedge i_clk) begin
        if (hold_cnt != 0) begin
            i_out_stall <= 1'b1;
            hold_cnt    <= hold_cnt - 1;
        end else if (hold_req && !hold_done) begin
            i_out_stall <= 1'b1;
            hold_cnt    <= HOLD_LEN;
            hold_done   <= 1'b1;
        end else begin
            i_out_stall <= !quiet && ($urandom_range(0, 99) < 36);
        end
    end

    // output checker
    always @(posedge i_clk) begin
        t_filter_out want;
        if (i_rst_n && o_out_valid && !i_out_stall) begin
            if (expected_outputs.size() == 0) begin
                report_mismatch("unexpected word", o_filtered_angle, 0);
            end else begin
                want = expected_outputs.pop_front();
                if (o_filtered_angle !== want.angle)
                    report_mismatch("filtered_angle", o_filtered_angle, want.angle);
                if (o_degenerate_gain !== want.degen)
                    report_mismatch("degenerate_gain", o_degenerate_gain, want.degen);
            end
        end
    end

    // config writes, back to back; valid lowered once at the end
    task automatic cfg_write(input logic [IDX_W-1:0] idx, input logic [REG_W-1:0] val);
        i_cfg_valid <= 1'b1;
        i_cfg_index <= idx;
        i_cfg_data  <= val;
        do @(posedge i_clk); while (!o_cfg_ready);
        filter_config(idx, val);
    endtask

    task automatic cfg_set(input logic [REG_W-1:0] qa, input logic [REG_W-1:0] qb,
                           input logic [REG_W-1:0] r);
        cfg_write(REG_QA, qa);
        cfg_write(REG_QB, qb);
        cfg_write(REG_R, r);
        i_cfg_valid <= 1'b0;
        @(posedge i_clk);
    endtask

    // sender pauses until every result is back
    task automatic drain();
        i_in_valid <= 1'b0;
        while (expected_outputs.size() != 0) @(posedge i_clk);
        repeat (8) @(posedge i_clk);
    endtask

    // offer one word; unless quiet, valid is sometimes lowered for a random pause before return
    task automatic send_word(input logic signed [31:0] meas, input logic signed [31:0] rate,
                             input logic [30:0] dt, input logic has_exp,
                             input t_filter_out typed);
        t_filter_out res;
        i_in_valid       <= 1'b1;
        i_measured_angle <= meas;
        i_gyro_rate      <= rate;
        i_time_step      <= dt;
        do @(posedge i_clk); while (o_in_stall);
        kf_predict_step(meas, rate, dt, res);
        expected_outputs.push_back(has_exp ? typed : res);
        if (!quiet && $urandom_range(0, 99) < 36) begin
            i_in_valid <= 1'b0;
            repeat ($urandom_range(1, 6)) @(posedge i_clk);
        end
    endtask

    function automatic logic [REG_W-1:0] rand_reg();
        case ($urandom_range(0, 4))
            0: return '0;
            1: return REG_MAX;
            2: return REG_W'($urandom());
            default: return REG_W'($urandom_range(0, 32'h0001_0000));
        endcase
    endfunction

    initial begin
        t_filter_out typed;
        t_row        row;
        logic signed [31:0] meas, rate;
        logic [30:0]        dt;
        int                 mode;

        i_rst_n          = 1'b0;
        i_in_valid       = 1'b0;
        i_measured_angle = '0;
        i_gyro_rate      = '0;
        i_time_step      = '0;
        i_out_stall      = 1'b0;
        i_cfg_valid      = 1'b0;
        i_cfg_index      = '0;
        i_cfg_data       = '0;
        quiet            = 1'b0;
        hold_req         = 1'b0;
        hold_done        = 1'b0;
        hold_cnt         = 0;
        err_count        = 0;
        cycle_count      = 0;

        cfg_qa = {1'b0, DEF_QA};
        cfg_qb = {1'b0, DEF_QB};
        cfg_r  = {1'b0, DEF_R};
        est_angle = '0; est_bias = '0;
        p00 = '0; p01 = '0; p10 = '0; p11 = '0;

        repeat (10) @(posedge i_clk);
        i_rst_n <= 1'b1;
        repeat (4) @(posedge i_clk);

        // directed table, config changes at phase boundaries
        for (int i = 0; i < N_DIR; i++) begin
            if (i == 7) begin
                drain();
                cfg_set('0, '0, '0);
            end else if (i == 10) begin
                drain();
                cfg_set(REG_MAX, REG_MAX, REG_MAX);
            end else if (i == 14) begin
                drain();
                cfg_write(REG_NONE, 31'h1234_5678);
                cfg_write(REG_QA, DEF_QA);
                cfg_write(REG_QB, DEF_QB);
                cfg_write(REG_R, DEF_R);
                i_cfg_valid <= 1'b0;
                @(posedge i_clk);
            end
            row = DIR_ROWS[i];
            typed.angle = row.exp_angle;
            typed.degen = row.exp_degen;
            send_word(row.meas, row.rate, row.dt, row.has_exp, typed);
        end

        // random phases, each with its own noise setting
        for (int ph = 0; ph < N_RAND_PHASES; ph++) begin
            drain();
            if (ph == 0)
                cfg_set(DEF_QA, DEF_QB, DEF_R);
            else
                cfg_set(rand_reg(), rand_reg(), rand_reg());
            quiet <= (ph == 3);
            for (int n = 0; n < WORDS_PER_PHASE; n++) begin
                if (ph == 2 && n == 100) hold_req <= 1'b1;
                mode = $urandom_range(0, 99);
                if (mode < 80) begin
                    // plausible sensor data: +-8 units, dt up to 0.1 s
                    meas = $signed($urandom_range(0, 32'h0100_0000)) - 32'sh0080_0000;
                    rate = $signed($urandom_range(0, 32'h0100_0000)) - 32'sh0080_0000;
                    dt   = 31'($urandom_range(1, 104858));
                end else if (mode < 90) begin
                    meas = $urandom();
                    rate = $urandom();
                    dt   = '0;
                end else begin
                    meas = $urandom();
                    rate = $urandom();
                    dt   = 31'($urandom());
                end
                send_word(meas, rate, dt, 1'b0, typed);
            end
        end

        drain();
        repeat (400) @(posedge i_clk);
        if (err_count == 0 && expected_outputs.size() == 0) begin
            $display("[ OK ] regression clean");
        end else begin
            $display("[FAIL] regression broken");
        end
        $finish;
    end

endmodule
